// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dmjs_pkg.sv =====
// ----------------------------------------------------------------------------
// dmjs_pkg
// word types, sequencer states and control structs for delay statistics
// ----------------------------------------------------------------------------
package dmjs_pkg;

    localparam int TIME_W  = 64;
    localparam int COUNT_W = 16;
    localparam int DELAY_W = 24;

    typedef struct packed {
        logic [TIME_W-1:0] capture_time_us;
        logic [TIME_W-1:0] arrival_time_us;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic [DELAY_W-1:0] delay_us;
        logic [DELAY_W-1:0] mean_us;
        logic [DELAY_W-1:0] jitter_us;
        logic               delay_clipped;
        logic               count_full;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_LD,
        ST_SQ_RUN,
        ST_ACCUM,
        ST_MEAN_LD,
        ST_MEAN_RUN,
        ST_NN_LD,
        ST_NN_RUN,
        ST_A_LD,
        ST_A_RUN,
        ST_B_LD,
        ST_B_RUN,
        ST_SUBT,
        ST_DIV_LD,
        ST_DIV_RUN,
        ST_SQRT_LD,
        ST_SQRT_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_valid;
        logic full;
        logic few;
        logic ge;
        logic out_free;
    } t_stat;

    typedef struct packed {
        t_state state;
        logic   last;
        logic   in_ready;
        logic   out_load;
    } t_ctrl;

endpackage

// ===== rtl/delay_mean_jitter_stats.sv =====
// ----------------------------------------------------------------------------
// delay_mean_jitter_stats
// running mean and jitter of packet delays over one shared add/subtract unit
// ----------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+-----------------------------
//  in       | i_in_valid / o_in_ready          | i_in_word  (two timestamps)
//  out      | o_out_valid / i_out_ready        | o_out_word (count and stats)
//
//  one word at a time: the next word is taken only once the result is loaded
//  at the output; each word runs through radix-2 steps of the shared add/subtract unit
//  a record taken when the count is full skips squaring and accumulation
//  jitter steps are skipped while fewer than two records are accumulated
//  reset clears the count, sum and square sum
//  a result waiting at the output holds the sequencer in its final state
// ----------------------------------------------------------------------------
module delay_mean_jitter_stats #(
    parameter int DELAY_BITS = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dmjs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dmjs_pkg::t_out_word o_out_word
);

    localparam int DB  = DELAY_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int SB  = DB + CB;
    localparam int QB  = 2 * DB + CB;
    localparam int PB  = QB + CB;
    localparam int TW  = dmjs_pkg::TIME_W;
    localparam int CW  = dmjs_pkg::COUNT_W;
    localparam int DW  = dmjs_pkg::DELAY_W;

    dmjs_pkg::t_ctrl w_ctrl;
    dmjs_pkg::t_stat w_stat;

    logic [PB-1:0] r_acc, n_acc;
    logic [PB-1:0] r_mq, n_mq;
    logic [PB-1:0] r_opb, n_opb;
    logic [PB-1:0] r_pa, n_pa;
    logic [2*CB-1:0] r_nn, n_nn;
    logic [DB-1:0] r_delay, n_delay;
    logic          r_clip, n_clip;
    logic          r_full, n_full;
    logic [DB-1:0] r_mean, n_mean;
    logic [DB-1:0] r_jit, n_jit;
    logic [CB-1:0] r_count, n_count;
    logic [SB-1:0] r_sum, n_sum;
    logic [QB-1:0] r_sumsq, n_sumsq;
    logic          r_out_valid;
    dmjs_pkg::t_out_word r_out_word;

    logic [TW-1:0] w_raw;
    logic          w_in_clip;
    logic [DB-1:0] w_in_delay;
    logic          w_in_acc;
    logic [PB-1:0] w_div_shift;
    logic [PB-1:0] w_sqrt_shift;
    logic [PB-1:0] w_add_a, w_add_b, w_add_res;
    logic          w_add_sub, w_add_ge;

    // delay of the incoming word, clipped to the delay range
    assign w_raw      = i_in_word.arrival_time_us - i_in_word.capture_time_us;
    assign w_in_clip  = |w_raw[TW-1:DB];
    assign w_in_delay = w_in_clip ? {DB{1'b1}} : w_raw[DB-1:0];
    assign w_in_acc   = i_in_valid && w_ctrl.in_ready;

    assign w_div_shift  = {r_acc[PB-2:0], r_mq[PB-1]};
    assign w_sqrt_shift = {r_acc[PB-3:0], r_mq[PB-1:PB-2]};

    assign w_stat.in_valid = i_in_valid;
    assign w_stat.full     = &r_count;
    assign w_stat.few      = (r_count[CB-1:1] == '0);
    assign w_stat.ge       = w_add_ge;
    assign w_stat.out_free = !r_out_valid || i_out_ready;

    dmjs_ctrl #(
        .DELAY_BITS(DELAY_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_ctrl (w_ctrl)
    );

    dmjs_addsub #(
        .WIDTH(PB)
    ) u_addsub (
        .i_a    (w_add_a),
        .i_b    (w_add_b),
        .i_sub  (w_add_sub),
        .o_sum  (w_add_res),
        .o_carry(w_add_ge)
    );

    // operand select for the shared unit
    always_comb begin
        w_add_a   = '0;
        w_add_b   = '0;
        w_add_sub = 1'b0;
        case (w_ctrl.state)
            dmjs_pkg::ST_SQ_RUN, dmjs_pkg::ST_NN_RUN,
            dmjs_pkg::ST_A_RUN, dmjs_pkg::ST_B_RUN: begin
                w_add_a = r_acc;
                w_add_b = r_mq[0] ? r_opb : '0;
            end
            dmjs_pkg::ST_MEAN_RUN, dmjs_pkg::ST_DIV_RUN: begin
                w_add_a   = w_div_shift;
                w_add_b   = r_opb;
                w_add_sub = 1'b1;
            end
            dmjs_pkg::ST_SUBT: begin
                w_add_a   = r_pa;
                w_add_b   = r_acc;
                w_add_sub = 1'b1;
            end
            dmjs_pkg::ST_SQRT_RUN: begin
                w_add_a   = w_sqrt_shift;
                w_add_b   = {r_opb[PB-3:0], 2'b01};
                w_add_sub = 1'b1;
            end
            default: begin
                w_add_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_acc   = r_acc;
        n_mq    = r_mq;
        n_opb   = r_opb;
        n_pa    = r_pa;
        n_nn    = r_nn;
        n_delay = r_delay;
        n_clip  = r_clip;
        n_full  = r_full;
        n_mean  = r_mean;
        n_jit   = r_jit;
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        case (w_ctrl.state)
            dmjs_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_delay = w_in_delay;
                    n_clip  = w_in_clip;
                    n_full  = w_stat.full;
                    n_mean  = '0;
                    n_jit   = '0;
                end
            end
            dmjs_pkg::ST_SQ_LD: begin
                n_acc = '0;
                n_mq  = PB'(r_delay);
                n_opb = PB'(r_delay);
            end
            dmjs_pkg::ST_SQ_RUN, dmjs_pkg::ST_NN_RUN,
            dmjs_pkg::ST_A_RUN, dmjs_pkg::ST_B_RUN: begin
                n_acc = w_add_res;
                n_opb = {r_opb[PB-2:0], 1'b0};
                n_mq  = {1'b0, r_mq[PB-1:1]};
                if (w_ctrl.last && w_ctrl.state == dmjs_pkg::ST_NN_RUN) begin
                    n_nn = w_add_res[2*CB-1:0];
                end
                if (w_ctrl.last && w_ctrl.state == dmjs_pkg::ST_A_RUN) begin
                    n_pa = w_add_res;
                end
            end
            dmjs_pkg::ST_ACCUM: begin
                n_count = r_count + CB'(1);
                n_sum   = r_sum + SB'(r_delay);
                n_sumsq = r_sumsq + QB'(r_acc[2*DB-1:0]);
            end
            dmjs_pkg::ST_MEAN_LD: begin
                n_acc = PB'(r_sum >> DB);
                n_mq  = PB'(r_sum[DB-1:0]) << (PB - DB);
                n_opb = PB'(r_count);
            end
            dmjs_pkg::ST_MEAN_RUN, dmjs_pkg::ST_DIV_RUN: begin
                n_acc = w_add_ge ? w_add_res : w_div_shift;
                n_mq  = {r_mq[PB-2:0], w_add_ge};
                if (w_ctrl.last && w_ctrl.state == dmjs_pkg::ST_MEAN_RUN) begin
                    n_mean = n_mq[DB-1:0];
                end
            end
            dmjs_pkg::ST_NN_LD: begin
                n_acc = '0;
                n_mq  = PB'(r_count);
                n_opb = PB'(r_count);
            end
            dmjs_pkg::ST_A_LD: begin
                n_acc = '0;
                n_mq  = PB'(r_count);
                n_opb = PB'(r_sumsq);
            end
            dmjs_pkg::ST_B_LD: begin
                n_acc = '0;
                n_mq  = PB'(r_sum);
                n_opb = PB'(r_sum);
            end
            dmjs_pkg::ST_SUBT: begin
                n_acc = w_add_res;
            end
            dmjs_pkg::ST_DIV_LD: begin
                n_acc = r_acc >> (2 * DB);
                n_mq  = r_acc << (PB - 2 * DB);
                n_opb = PB'(r_nn);
            end
            dmjs_pkg::ST_SQRT_LD: begin
                n_acc = '0;
                n_opb = '0;
                n_mq  = r_mq << (PB - 2 * DB);
            end
            dmjs_pkg::ST_SQRT_RUN: begin
                n_mq = {r_mq[PB-3:0], 2'b00};
                if (w_add_ge) begin
                    n_acc = w_add_res;
                    n_opb = {r_opb[PB-2:0], 1'b1};
                end else begin
                    n_acc = w_sqrt_shift;
                    n_opb = {r_opb[PB-2:0], 1'b0};
                end
                if (w_ctrl.last) begin
                    n_jit = n_opb[DB-1:0];
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_mq    <= n_mq;
        r_opb   <= n_opb;
        r_pa    <= n_pa;
        r_nn    <= n_nn;
        r_delay <= n_delay;
        r_clip  <= n_clip;
        r_full  <= n_full;
        r_mean  <= n_mean;
        r_jit   <= n_jit;
        if (w_ctrl.out_load) begin
            r_out_word.sample_count  <= CW'(r_count);
            r_out_word.delay_us      <= DW'(r_delay);
            r_out_word.mean_us       <= DW'(r_mean);
            r_out_word.jitter_us     <= DW'(r_jit);
            r_out_word.delay_clipped <= r_clip;
            r_out_word.count_full    <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            if (w_ctrl.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = w_ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/dmjs_addsub.sv =====
// ----------------------------------------------------------------------------
// dmjs_addsub
// shared add/subtract unit; carry out is the no-borrow flag on subtract
// ----------------------------------------------------------------------------
module dmjs_addsub #(
    parameter int WIDTH = 80
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    logic [WIDTH:0] w_full;
    logic [WIDTH-1:0] w_b;

    assign w_b    = i_sub ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + {{WIDTH{1'b0}}, i_sub};
    assign o_sum   = w_full[WIDTH-1:0];
    assign o_carry = w_full[WIDTH];

endmodule

// ===== rtl/dmjs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmjs_ctrl
// sequencer for the shared unit: operation order and step counting
// ----------------------------------------------------------------------------
module dmjs_ctrl #(
    parameter int DELAY_BITS = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dmjs_pkg::t_stat i_stat,
    output dmjs_pkg::t_ctrl o_ctrl
);

    localparam int DB    = DELAY_BITS;
    localparam int CB    = COUNT_BITS;
    localparam int SB    = DB + CB;
    localparam int MAXS  = (2 * DB > SB) ? 2 * DB : SB;
    localparam int CNT_W = $clog2(MAXS + 1);

    dmjs_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_last;

    assign w_last = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmjs_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            dmjs_pkg::ST_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = i_stat.full ? dmjs_pkg::ST_MEAN_LD : dmjs_pkg::ST_SQ_LD;
                end
            end
            dmjs_pkg::ST_SQ_LD: begin
                n_state = dmjs_pkg::ST_SQ_RUN;
                n_cnt   = CNT_W'(DB);
            end
            dmjs_pkg::ST_SQ_RUN: begin
                if (w_last) n_state = dmjs_pkg::ST_ACCUM;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_ACCUM: begin
                n_state = dmjs_pkg::ST_MEAN_LD;
            end
            dmjs_pkg::ST_MEAN_LD: begin
                n_state = dmjs_pkg::ST_MEAN_RUN;
                n_cnt   = CNT_W'(DB);
            end
            dmjs_pkg::ST_MEAN_RUN: begin
                if (w_last) n_state = i_stat.few ? dmjs_pkg::ST_DONE : dmjs_pkg::ST_NN_LD;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_NN_LD: begin
                n_state = dmjs_pkg::ST_NN_RUN;
                n_cnt   = CNT_W'(CB);
            end
            dmjs_pkg::ST_NN_RUN: begin
                if (w_last) n_state = dmjs_pkg::ST_A_LD;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_A_LD: begin
                n_state = dmjs_pkg::ST_A_RUN;
                n_cnt   = CNT_W'(CB);
            end
            dmjs_pkg::ST_A_RUN: begin
                if (w_last) n_state = dmjs_pkg::ST_B_LD;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_B_LD: begin
                n_state = dmjs_pkg::ST_B_RUN;
                n_cnt   = CNT_W'(SB);
            end
            dmjs_pkg::ST_B_RUN: begin
                if (w_last) n_state = dmjs_pkg::ST_SUBT;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_SUBT: begin
                n_state = i_stat.ge ? dmjs_pkg::ST_DIV_LD : dmjs_pkg::ST_DONE;
            end
            dmjs_pkg::ST_DIV_LD: begin
                n_state = dmjs_pkg::ST_DIV_RUN;
                n_cnt   = CNT_W'(2 * DB);
            end
            dmjs_pkg::ST_DIV_RUN: begin
                if (w_last) n_state = dmjs_pkg::ST_SQRT_LD;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_SQRT_LD: begin
                n_state = dmjs_pkg::ST_SQRT_RUN;
                n_cnt   = CNT_W'(DB);
            end
            dmjs_pkg::ST_SQRT_RUN: begin
                if (w_last) n_state = dmjs_pkg::ST_DONE;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            dmjs_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = dmjs_pkg::ST_IDLE;
            end
            default: begin
                n_state = dmjs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl.state    = r_state;
        o_ctrl.last     = w_last;
        o_ctrl.in_ready = (r_state == dmjs_pkg::ST_IDLE);
        o_ctrl.out_load = (r_state == dmjs_pkg::ST_DONE) && i_stat.out_free;
    end

endmodule

// ===== rtl/dmjs_check.sv =====
// ----------------------------------------------------------------------------
// dmjs_check
// port-level checks for delay_mean_jitter_stats, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmjs_check #(
    parameter int DELAY_BITS = 24,
    parameter int COUNT_BITS = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dmjs_pkg::t_out_word o_out_word
);

    localparam int CW = dmjs_pkg::COUNT_W;
    localparam int DW = dmjs_pkg::DELAY_W;
    localparam logic [CW-1:0] CNT_MAX = CW'((1 << COUNT_BITS) - 1);
    localparam logic [DW-1:0] DLY_MAX = DW'((1 << DELAY_BITS) - 1);

    logic w_in_acc;
    logic w_out_stall;
    logic w_clip_show;
    logic w_full_show;
    logic w_few_show;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_clip_show = o_out_valid && o_out_word.delay_clipped;
    assign w_full_show = o_out_valid && o_out_word.count_full;
    assign w_few_show  = o_out_valid && (o_out_word.sample_count[CW-1:1] == '0);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_out_word))
    `ASSERT_NEXT(a_busy_after_word, i_clk, i_rst_n, w_in_acc, !o_in_ready)
    `ASSERT_IMPLY(a_clip_max, i_clk, i_rst_n, w_clip_show, o_out_word.delay_us == DLY_MAX)
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, w_full_show, o_out_word.sample_count == CNT_MAX)
    `ASSERT_IMPLY(a_few_no_jitter, i_clk, i_rst_n, w_few_show, o_out_word.jitter_us == '0)

endmodule

bind delay_mean_jitter_stats dmjs_check #(
    .DELAY_BITS(DELAY_BITS),
    .COUNT_BITS(COUNT_BITS)
) u_dmjs_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_word (o_out_word)
);

// ===== sim/tb_delay_mean_jitter_stats.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delay_mean_jitter_stats
// self-checking bench for the packet delay mean and jitter statistics block
//
// timestamp words are queued up front: a directed set covering zero and
// maximum delay, the clipping boundary, wrapped arrivals and equal delays,
// then random words, mostly small or near-boundary delays. each accepted word
// is run through a local model of the count, sum and square sum, and the
// expected stats word is queued. every result word is compared field by field
// with the oldest expected one. both sides idle at random in two phases, then neither.
// ----------------------------------------------------------------------------
module tb_delay_mean_jitter_stats;

    localparam int          DLY_BITS       = 24;
    localparam int          CNT_BITS       = 16;
    localparam logic [63:0] DLY_MAX        = (64'd1 << DLY_BITS) - 64'd1;
    localparam logic [63:0] CNT_MAX        = (64'd1 << CNT_BITS) - 64'd1;
    localparam int          RANDOM_WORDS   = 1040;
    localparam int          SETTLE_CYCLES  = 250;
    localparam int          WATCHDOG_LIMIT = 5000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    dmjs_pkg::t_in_word  i_in_word   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    dmjs_pkg::t_out_word o_out_word;

    dmjs_pkg::t_in_word  pending_words[$];
    dmjs_pkg::t_out_word stats_expected[$];

    logic [63:0] acc_count = '0;
    logic [63:0] acc_sum   = '0;
    logic [63:0] acc_sqsum = '0;

    int   errors     = 0;
    int   words_in   = 0;
    int   idle_count = 0;
    logic in_taken   = 1'b0;

    delay_mean_jitter_stats #(
        .DELAY_BITS(DLY_BITS),
        .COUNT_BITS(CNT_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] r;
        r = '0;
        for (int k = 31; k >= 0; k--) begin
            r[k] = 1'b1;
            if ({32'd0, r} * {32'd0, r} > x) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic dmjs_pkg::t_out_word predict_stats(input dmjs_pkg::t_in_word w);
        dmjs_pkg::t_out_word res;
        logic [63:0] raw;
        logic [63:0] dly;
        logic [63:0] mean;
        logic [63:0] jitter;
        logic [127:0] n_w;
        logic [127:0] s_w;
        logic [127:0] q_w;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] spread;
        res    = '0;
        mean   = '0;
        jitter = '0;
        raw    = w.arrival_time_us - w.capture_time_us;
        res.delay_clipped = (raw > DLY_MAX);
        dly    = res.delay_clipped ? DLY_MAX : raw;
        res.count_full = (acc_count >= CNT_MAX);
        if (!res.count_full) begin
            acc_count = acc_count + 64'd1;
            acc_sum   = acc_sum + dly;
            acc_sqsum = acc_sqsum + dly * dly;
        end
        if (acc_count != 0) begin
            mean = acc_sum / acc_count;
        end
        if (acc_count >= 2) begin
            n_w = {64'd0, acc_count};
            s_w = {64'd0, acc_sum};
            q_w = {64'd0, acc_sqsum};
            lhs = n_w * q_w;
            rhs = s_w * s_w;
            if (lhs >= rhs) begin
                spread = (lhs - rhs) / (n_w * n_w);
                jitter = {32'd0, floor_sqrt(spread[63:0])};
            end
        end
        res.sample_count = acc_count[15:0];
        res.delay_us     = dly[23:0];
        res.mean_us      = mean[23:0];
        res.jitter_us    = jitter[23:0];
        return res;
    endfunction

    task automatic push_word(input logic [63:0] cap, input logic [63:0] arr);
        dmjs_pkg::t_in_word w;
        w.capture_time_us = cap;
        w.arrival_time_us = arr;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 100) begin
            $display("tb: error at %0t: %s", $time, msg);
        end
    endtask

    // sender and receiver idling by phase
    always @(negedge i_clk) begin : drive
        int send_idle;
        int recv_idle;
        if (words_in < 350) begin
            send_idle = 28;
            recv_idle = 82;
        end else if (words_in < 700) begin
            send_idle = 82;
            recv_idle = 28;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                i_in_valid <= 1'b1;
                i_in_word  <= pending_words.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin : monitor
        dmjs_pkg::t_out_word want;
        dmjs_pkg::t_out_word got;
        logic                moved;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        moved    = in_taken;
        if (in_taken) begin
            stats_expected.insert(stats_expected.size(), predict_stats(i_in_word));
            words_in++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            moved = 1'b1;
            got   = o_out_word;
            if (stats_expected.size() == 0) begin
                report_error("result word with none expected");
            end else begin
                want = stats_expected.pop_front();
                if (got.sample_count != want.sample_count)
                    report_error($sformatf("sample_count %0d, expected %0d",
                        got.sample_count, want.sample_count));
                if (got.delay_us != want.delay_us)
                    report_error($sformatf("delay_us %0d, expected %0d",
                        got.delay_us, want.delay_us));
                if (got.mean_us != want.mean_us)
                    report_error($sformatf("mean_us %0d, expected %0d",
                        got.mean_us, want.mean_us));
                if (got.jitter_us != want.jitter_us)
                    report_error($sformatf("jitter_us %0d, expected %0d",
                        got.jitter_us, want.jitter_us));
                if (got.delay_clipped != want.delay_clipped)
                    report_error($sformatf("delay_clipped %0b, expected %0b",
                        got.delay_clipped, want.delay_clipped));
                if (got.count_full != want.count_full)
                    report_error($sformatf("count_full %0b, expected %0b",
                        got.count_full, want.count_full));
            end
        end
        idle_count = moved ? 0 : idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [63:0] cap;
        logic [63:0] arr;
        push_word(64'd0, 64'd0);
        push_word(64'd0, DLY_MAX);
        push_word(64'd100, 64'd100 + DLY_MAX + 64'd1);
        push_word(64'd5, 64'd4);
        push_word('1, 64'd0);
        push_word('1, '1);
        push_word(64'd0, '1);
        push_word(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        push_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_3039);
        for (int k = 0; k < 4; k++) begin
            cap = rand64();
            push_word(cap, cap + 64'd777);
        end
        cap = rand64();
        push_word(cap, cap + DLY_MAX - 64'd1);
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            cap = rand64();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    arr = cap + (rand64() >> $urandom_range(40, 63));
                end
                5, 6: begin
                    arr = cap + DLY_MAX + $urandom_range(0, 6) - 64'd3;
                end
                7: begin
                    arr = cap - (rand64() >> $urandom_range(0, 63)) - 64'd1;
                end
                default: begin
                    arr = rand64();
                end
            endcase
            push_word(cap, arr);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid) @(posedge i_clk);
        while (stats_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
